// File: rtl/asc_pkg.sv
`timescale 1ns / 1ps

package asc_pkg;

	localparam int NAME_CAPACITY = 32;
	localparam int NAME_CNT_W    = $clog2(NAME_CAPACITY);

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	localparam logic [7:0] AD_UUID16_INCOMPLETE  = 8'h02;
	localparam logic [7:0] AD_UUID16_COMPLETE    = 8'h03;
	localparam logic [7:0] AD_UUID128_INCOMPLETE = 8'h06;
	localparam logic [7:0] AD_UUID128_COMPLETE   = 8'h07;
	localparam logic [7:0] AD_NAME_SHORT         = 8'h08;
	localparam logic [7:0] AD_NAME_COMPLETE      = 8'h09;

	localparam logic [15:0] SHORT_UUID_RESET = 16'h1826;

	localparam logic [3:0] CHUNK_LAST = 4'd15;

	localparam logic RK_NAME    = 1'b0;
	localparam logic RK_SUMMARY = 1'b1;

	localparam logic [1:0] MT_NONE  = 2'd0;
	localparam logic [1:0] MT_LONG  = 2'd1;
	localparam logic [1:0] MT_SHORT = 2'd2;

	typedef enum logic [1:0] {
		REG_SHORT_UUID     = 2'd0,
		REG_LONG_UUID_LOW  = 2'd1,
		REG_LONG_UUID_HIGH = 2'd2
	} reg_index_t;

	typedef enum logic [2:0] {
		OP_NONE    = 3'd0,
		OP_PAIR_LO = 3'd1,
		OP_PAIR_HI = 3'd2,
		OP_CHUNK   = 3'd3,
		OP_NAME    = 3'd4
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] data;
		logic [3:0] chunk_idx;
		logic [4:0] name_pos;
		logic       last;
		logic [4:0] name_len;
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] name_char;
		logic [4:0] name_pos;
		logic       short_found;
		logic       long_found;
		logic [1:0] mtype;
		logic [4:0] name_len;
		logic       last;
	} res_t;

	function automatic logic [4:0] to_pos5(input logic [NAME_CNT_W-1:0] cnt);
		logic [NAME_CNT_W+4:0] w;
		w = (NAME_CNT_W + 5)'(cnt);
		return w[4:0];
	endfunction

endpackage

// File: rtl/asc_front.sv
`timescale 1ns / 1ps

module asc_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [7:0]   data_byte,
	input  logic [7:0]   report_length,
	input  logic         cmd_full,
	output logic         cmd_push,
	output asc_pkg::cmd_t cmd
);
	import asc_pkg::*;

	logic [7:0]            pos_q, pos_d;
	logic [7:0]            left_q, left_d;
	logic [7:0]            stype_q, stype_d;
	logic                  type_pend_q, type_pend_d;
	logic                  stopped_q, stopped_d;
	logic [3:0]            chunk_cnt_q, chunk_cnt_d;
	logic                  pair_phase_q, pair_phase_d;
	logic                  name_done_q, name_done_d;
	logic                  name_active_q, name_active_d;
	logic [NAME_CNT_W-1:0] name_cnt_q, name_cnt_d;

	logic       accept;
	logic [9:0] struct_end;
	logic       overrun;
	logic       is_final;
	cmd_op_t    op;

	assign accept     = push && !cmd_full;
	assign struct_end = 10'(pos_q) + 10'd1 + 10'(data_byte);
	assign overrun    = struct_end > 10'(report_length);
	assign is_final   = (9'(pos_q) + 9'd1) >= 9'(report_length);

	always_comb begin
		pos_d         = pos_q;
		left_d        = left_q;
		stype_d       = stype_q;
		type_pend_d   = type_pend_q;
		stopped_d     = stopped_q;
		chunk_cnt_d   = chunk_cnt_q;
		pair_phase_d  = pair_phase_q;
		name_done_d   = name_done_q;
		name_active_d = name_active_q;
		name_cnt_d    = name_cnt_q;
		op            = OP_NONE;

		if (!stopped_q) begin
			if (left_q == 8'd0) begin
				if (data_byte == 8'd0 || overrun) begin
					stopped_d = 1'b1;
				end else begin
					left_d      = data_byte;
					type_pend_d = 1'b1;
				end
			end else if (type_pend_q) begin
				stype_d       = data_byte;
				type_pend_d   = 1'b0;
				left_d        = left_q - 8'd1;
				pair_phase_d  = 1'b0;
				chunk_cnt_d   = 4'd0;
				name_active_d = 1'b0;
				if ((data_byte == AD_NAME_SHORT || data_byte == AD_NAME_COMPLETE)
						&& !name_done_q) begin
					name_done_d   = 1'b1;
					name_active_d = 1'b1;
				end
			end else begin
				left_d = left_q - 8'd1;
				if (stype_q == AD_UUID16_INCOMPLETE || stype_q == AD_UUID16_COMPLETE) begin
					op           = pair_phase_q ? OP_PAIR_HI : OP_PAIR_LO;
					pair_phase_d = !pair_phase_q;
				end else if (stype_q == AD_UUID128_INCOMPLETE
						|| stype_q == AD_UUID128_COMPLETE) begin
					op          = OP_CHUNK;
					chunk_cnt_d = chunk_cnt_q + 4'd1;
				end else if (name_active_q
						&& name_cnt_q < NAME_CNT_W'(NAME_CAPACITY - 1)) begin
					op         = OP_NAME;
					name_cnt_d = name_cnt_q + NAME_CNT_W'(1);
				end
			end
		end

		cmd.op        = op;
		cmd.data      = data_byte;
		cmd.chunk_idx = chunk_cnt_q;
		cmd.name_pos  = to_pos5(name_cnt_q);
		cmd.last      = is_final;
		cmd.name_len  = to_pos5(name_cnt_d);

		if (is_final) begin
			pos_d         = 8'd0;
			left_d        = 8'd0;
			stype_d       = 8'd0;
			type_pend_d   = 1'b0;
			stopped_d     = 1'b0;
			chunk_cnt_d   = 4'd0;
			pair_phase_d  = 1'b0;
			name_done_d   = 1'b0;
			name_active_d = 1'b0;
			name_cnt_d    = '0;
		end else begin
			pos_d = pos_q + 8'd1;
		end

		cmd_push = accept && (op != OP_NONE || is_final);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= 8'd0;
			left_q        <= 8'd0;
			stype_q       <= 8'd0;
			type_pend_q   <= 1'b0;
			stopped_q     <= 1'b0;
			chunk_cnt_q   <= 4'd0;
			pair_phase_q  <= 1'b0;
			name_done_q   <= 1'b0;
			name_active_q <= 1'b0;
			name_cnt_q    <= '0;
		end else if (accept) begin
			pos_q         <= pos_d;
			left_q        <= left_d;
			stype_q       <= stype_d;
			type_pend_q   <= type_pend_d;
			stopped_q     <= stopped_d;
			chunk_cnt_q   <= chunk_cnt_d;
			pair_phase_q  <= pair_phase_d;
			name_done_q   <= name_done_d;
			name_active_q <= name_active_d;
			name_cnt_q    <= name_cnt_d;
		end
	end

endmodule

// File: rtl/asc_cmd_queue.sv
`timescale 1ns / 1ps

module asc_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  asc_pkg::cmd_t din,
	input  logic          pop,
	output asc_pkg::cmd_t dout,
	output logic          full,
	output logic          empty
);
	import asc_pkg::*;

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMD_CNT_W-1:0] cnt_q;
	logic                 do_push, do_pop;

	assign full    = cnt_q == CMD_CNT_W'(CMD_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
					: wr_ptr_q + CMD_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
					: rd_ptr_q + CMD_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CMD_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CMD_CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/asc_back.sv
`timescale 1ns / 1ps

module asc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [63:0]   wr_data,
	input  logic          cmd_empty,
	input  asc_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          pop,
	output logic          empty,
	output asc_pkg::res_t res
);
	import asc_pkg::*;

	logic [15:0] short_uuid_q;
	logic [63:0] long_low_q;
	logic [63:0] long_high_q;

	logic [7:0]  pair_lo_q;
	logic [7:0]  chunk_q [16];
	logic        short_hit_q, short_hit_d;
	logic        long_hit_q, long_hit_d;
	logic        split_q, split_d;

	res_t                 res_mem_q [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 res_space;
	logic                 res_push;
	logic                 res_pop;
	res_t                 res_d;

	logic [127:0] chunk_full;
	logic         act;
	logic         upd;
	logic         wants_push;
	logic         is_name;

	assign res_space = cnt_q != RES_CNT_W'(RES_DEPTH);
	assign empty     = cnt_q == '0;
	assign res_pop   = pop && !empty;
	assign res       = res_mem_q[rd_ptr_q];
	assign is_name   = cmd.op == OP_NAME;

	always_comb begin
		for (int i = 0; i < 15; i++) begin
			chunk_full[8*i +: 8] = chunk_q[i];
		end
		chunk_full[127:120] = cmd.data;
	end

	always_comb begin
		wants_push  = is_name || cmd.last;
		act         = !cmd_empty && (!wants_push || res_space);
		upd         = act && !split_q;
		short_hit_d = short_hit_q;
		long_hit_d  = long_hit_q;
		if (upd && cmd.op == OP_PAIR_HI && {cmd.data, pair_lo_q} == short_uuid_q) begin
			short_hit_d = 1'b1;
		end
		if (upd && cmd.op == OP_CHUNK && cmd.chunk_idx == CHUNK_LAST
				&& chunk_full == {long_high_q, long_low_q}) begin
			long_hit_d = 1'b1;
		end

		split_d  = split_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		res_d    = '0;
		if (act) begin
			if (is_name && !split_q) begin
				res_push       = 1'b1;
				res_d.kind     = RK_NAME;
				res_d.name_char = cmd.data;
				res_d.name_pos = cmd.name_pos;
				split_d        = cmd.last;
				cmd_pop        = !cmd.last;
			end else begin
				cmd_pop = 1'b1;
				split_d = 1'b0;
				if (cmd.last) begin
					res_push          = 1'b1;
					res_d.kind        = RK_SUMMARY;
					res_d.short_found = short_hit_d;
					res_d.long_found  = long_hit_d;
					res_d.mtype       = long_hit_d ? MT_LONG
						: (short_hit_d ? MT_SHORT : MT_NONE);
					res_d.name_len    = cmd.name_len;
					res_d.last        = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd && cmd.op == OP_PAIR_LO) begin
			pair_lo_q <= cmd.data;
		end
		if (upd && cmd.op == OP_CHUNK) begin
			chunk_q[cmd.chunk_idx] <= cmd.data;
		end
		if (res_push) begin
			res_mem_q[wr_ptr_q] <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_uuid_q <= SHORT_UUID_RESET;
			long_low_q   <= 64'd0;
			long_high_q  <= 64'd0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SHORT_UUID:     short_uuid_q <= wr_data[15:0];
				REG_LONG_UUID_LOW:  long_low_q   <= wr_data;
				REG_LONG_UUID_HIGH: long_high_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_hit_q <= 1'b0;
			long_hit_q  <= 1'b0;
			split_q     <= 1'b0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			cnt_q       <= '0;
		end else begin
			split_q <= split_d;
			if (cmd_pop && cmd.last) begin
				short_hit_q <= 1'b0;
				long_hit_q  <= 1'b0;
			end else begin
				short_hit_q <= short_hit_d;
				long_hit_q  <= long_hit_d;
			end
			if (res_push) begin
				wr_ptr_q <= (wr_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0
					: wr_ptr_q + RES_PTR_W'(1);
			end
			if (res_pop) begin
				rd_ptr_q <= (rd_ptr_q == RES_PTR_W'(RES_DEPTH - 1)) ? '0
					: rd_ptr_q + RES_PTR_W'(1);
			end
			if (res_push && !res_pop) begin
				cnt_q <= cnt_q + RES_CNT_W'(1);
			end else if (res_pop && !res_push) begin
				cnt_q <= cnt_q - RES_CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/adv_structure_scanner.sv
// Path: a byte's command is registered in the command queue and its result in the result
// queue before it shows on the result ports; the summary of a final byte that also carries
// a name byte follows its name result. Throughput: one byte per cycle while full is low;
// the summary step of such a final byte is a separate step in the back-end command unit.
// Reset: arst_n at once clears both queues and all scan state but the captured UUID bytes,
// and loads the UUID registers with their defaults (short UUID 0x1826, 128-bit UUID zero).
`timescale 1ns / 1ps

module adv_structure_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  report_length,
	output logic        empty,
	input  logic        pop,
	output logic        result_kind,
	output logic [7:0]  name_char,
	output logic [4:0]  name_position,
	output logic        short_uuid_found,
	output logic        long_uuid_found,
	output logic [1:0]  machine_type,
	output logic [4:0]  name_length,
	output logic        last_result,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data
);
	import asc_pkg::*;

	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_pop, cmd_full, cmd_empty;
	res_t res;

	assign full = cmd_full;

	asc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.data_byte     (data_byte),
		.report_length (report_length),
		.cmd_full      (cmd_full),
		.cmd_push      (cmd_push),
		.cmd           (cmd_in)
	);

	asc_cmd_queue u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.din    (cmd_in),
		.pop    (cmd_pop),
		.dout   (cmd_out),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	asc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign result_kind      = res.kind;
	assign name_char        = res.name_char;
	assign name_position    = res.name_pos;
	assign short_uuid_found = res.short_found;
	assign long_uuid_found  = res.long_found;
	assign machine_type     = res.mtype;
	assign name_length      = res.name_len;
	assign last_result      = res.last;

endmodule

// File: rtl/asc_checker.sv
`timescale 1ns / 1ps

module asc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       result_kind,
	input logic [7:0] name_char,
	input logic [4:0] name_position,
	input logic       short_uuid_found,
	input logic       long_uuid_found,
	input logic [1:0] machine_type,
	input logic [4:0] name_length,
	input logic       last_result
);
	import asc_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> last_result == result_kind)
		else $error("last_result disagrees with result_kind");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind == RK_NAME |->
			!short_uuid_found && !long_uuid_found && machine_type == MT_NONE
			&& name_length == 5'd0 && name_position != 5'd31)
		else $error("name transfer carries summary fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind == RK_SUMMARY |->
			(long_uuid_found && machine_type == MT_LONG)
			|| (!long_uuid_found && short_uuid_found && machine_type == MT_SHORT)
			|| (!long_uuid_found && !short_uuid_found && machine_type == MT_NONE))
		else $error("machine_type inconsistent with found flags");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result_kind) && $stable(name_char)
			&& $stable(name_length))
		else $error("waiting result changed before transfer");

endmodule

bind adv_structure_scanner asc_checker u_asc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.empty            (empty),
	.pop              (pop),
	.result_kind      (result_kind),
	.name_char        (name_char),
	.name_position    (name_position),
	.short_uuid_found (short_uuid_found),
	.long_uuid_found  (long_uuid_found),
	.machine_type     (machine_type),
	.name_length      (name_length),
	.last_result      (last_result)
);
